// ===== rtl/core/etft_pkg.sv =====
// Package for the torque-to-throttle inverse engine model.
// Holds shared constants, cosine series tables and the pipeline structs; no dependencies.
`default_nettype none
package etft_pkg;

	localparam int FRAC_BITS_DEF = 16;

	// throttle output is Q1.16
	localparam int          OUT_W   = 17;
	localparam logic [16:0] OUT_ONE = 17'h10000;

	// pi/2 and 1.0 in Q1.30
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [30:0] Q30_ONE     = 31'd1073741824;

	// cosine series: term k is divided by (2k-1)*2k, using floor(2^32 / divisor)
	localparam int N_TERMS = 8;
	localparam logic [7:0]  TERM_DIV [1:N_TERMS] = '{
		8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132, 8'd182, 8'd240};
	localparam logic [31:0] TERM_RCP [1:N_TERMS] = '{
		32'd2147483648, 32'd357913941, 32'd143165576, 32'd76695844,
		32'd47721858, 32'd32537631, 32'd23598721, 32'd17895697};

	// stages in one bit step of the throttle search
	localparam int SRCH_STAGES = 3 + 3 * N_TERMS;
	localparam int SRCH_BITS   = 17;

	// configuration register indexes (address bit 2)
	localparam logic REG_COEF_A = 1'b0;
	localparam logic REG_COEF_B = 1'b1;

	typedef struct packed {
		logic vld;
		logic force0;  // zero speed: answer 0
		logic full;    // cosine target zero: answer full throttle
	} etft_ctl_t;

	typedef struct packed {
		etft_ctl_t          ctl;
		logic [16:0]        y;
		logic [30:0]        tgt;
		logic               ok;
		logic [16:0]        cand;
		logic [31:0]        x2;
		logic [31:0]        v;
		logic [30:0]        term;
		logic signed [33:0] sum;
	} etft_cos_t;

endpackage
`default_nettype wire

// ===== rtl/core/etft_srch.sv =====
// One bit step of the throttle search: evaluates the cosine series of a candidate.
// Depends on etft_pkg for series tables and the stage struct.
`default_nettype none
module etft_srch import etft_pkg::*; #(
	parameter int BIT = 16
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        en,
	input  wire etft_ctl_t   ctl_i,
	input  wire logic [16:0] y_i,
	input  wire logic [30:0] tgt_i,
	output etft_ctl_t        ctl_o,
	output logic [16:0]      y_o,
	output logic [30:0]      tgt_o
);

	etft_cos_t cos_s [SRCH_STAGES];
	etft_cos_t nxt   [SRCH_STAGES];

	for (genvar j = 0; j < SRCH_STAGES; j++) begin : g_st
		if (j == 0) begin : g_x
			// candidate and angle x = pi/2 * cand
			always_comb begin
				logic [47:0] prd;
				prd = 48'(HALF_PI_Q30) * 48'(y_i | (17'd1 << BIT));
				nxt[j]      = '0;
				nxt[j].ctl  = ctl_i;
				nxt[j].y    = y_i;
				nxt[j].tgt  = tgt_i;
				nxt[j].cand = y_i | (17'd1 << BIT);
				nxt[j].ok   = (y_i | (17'd1 << BIT)) <= OUT_ONE;
				nxt[j].x2   = {1'b0, prd[46:16]};
				nxt[j].term = Q30_ONE;
				nxt[j].sum  = 34'(Q30_ONE);
			end
		end else if (j == 1) begin : g_x2
			always_comb begin
				logic [61:0] prd;
				prd = 62'(cos_s[j-1].x2[30:0]) * 62'(cos_s[j-1].x2[30:0]);
				nxt[j]    = cos_s[j-1];
				nxt[j].x2 = prd[61:30];
			end
		end else if (j < SRCH_STAGES - 1) begin : g_term
			localparam int K   = (j - 2) / 3 + 1;
			localparam int PH  = (j - 2) % 3;
			localparam bit NEG = ((K - 1) % 2) == 1;
			if (PH == 0) begin : g_mul
				// scale previous term by x^2, fold previous term into the sum
				always_comb begin
					logic [62:0] prd;
					prd = 63'(cos_s[j-1].term) * 63'(cos_s[j-1].x2);
					nxt[j]   = cos_s[j-1];
					nxt[j].v = prd[61:30];
					if (K > 1) begin
						if (NEG)
							nxt[j].sum = cos_s[j-1].sum - $signed(34'(cos_s[j-1].term));
						else
							nxt[j].sum = cos_s[j-1].sum + $signed(34'(cos_s[j-1].term));
					end
				end
			end else if (PH == 1) begin : g_rcp
				// quotient estimate, at most one low
				always_comb begin
					logic [63:0] prd;
					prd = 64'(cos_s[j-1].v) * 64'(TERM_RCP[K]);
					nxt[j]      = cos_s[j-1];
					nxt[j].term = prd[62:32];
				end
			end else begin : g_fix
				always_comb begin
					logic [39:0] rmd;
					rmd = 40'(cos_s[j-1].v) - 40'(cos_s[j-1].term) * 40'(TERM_DIV[K]);
					nxt[j]      = cos_s[j-1];
					nxt[j].term = cos_s[j-1].term + 31'(rmd >= 40'(TERM_DIV[K]));
				end
			end
		end else begin : g_cmp
			// last term is added; keep the bit when the candidate is at most 1.0 and cos >= target
			always_comb begin
				logic signed [33:0] sm;
				sm = cos_s[j-1].sum + $signed(34'(cos_s[j-1].term));
				nxt[j]     = cos_s[j-1];
				nxt[j].sum = sm;
				if (cos_s[j-1].ok && (sm >= $signed({3'b000, cos_s[j-1].tgt})))
					nxt[j].y = cos_s[j-1].cand;
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				cos_s[j] <= '0;
			end else if (en) begin
				cos_s[j] <= nxt[j];
			end
		end
	end

	assign ctl_o = cos_s[SRCH_STAGES-1].ctl;
	assign y_o   = cos_s[SRCH_STAGES-1].y;
	assign tgt_o = cos_s[SRCH_STAGES-1].tgt;

endmodule
`default_nettype wire

// ===== rtl/core/engine_throttle_from_torque.sv =====
// Each word passes 537 register stages (at FRAC_BITS = 16) from the accepting edge
// to the output register. Throughput: one word per cycle while no result waits stalled;
// every divider, root and cosine step is its own stage.
// The 17-step throttle search dominates latency: 27 stages per bit, at most one multiplier each.
// Reset (arst_n low, asynchronous) empties the pipeline and loads coef_a = coef_b = 1.0.
// Top level: depends on etft_pkg and etft_srch.
`default_nettype none
module engine_throttle_from_torque import etft_pkg::*; #(
	parameter int FRAC_BITS = FRAC_BITS_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	// configuration
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	// command words
	input  wire logic              cmd_valid,
	output logic                   cmd_stall,
	input  wire logic [31:0]       torque_demand,
	input  wire logic [31:0]       shaft_speed,
	// result words
	output logic                   res_valid,
	input  wire logic              res_stall,
	output logic [OUT_W-1:0]       throttle
);

	localparam int RN  = (32 + FRAC_BITS + 1) / 2;  // root bits
	localparam int SW  = 2 * RN;                     // radicand bits, padded even
	localparam int RW  = RN + 2;                     // root remainder bits
	localparam int TSH = 30 - FRAC_BITS;
	localparam logic [FRAC_BITS:0] ONE = (FRAC_BITS+1)'(1) << FRAC_BITS;

	logic [31:0] coef_a_q, coef_b_q;
	logic        en;

	// ---------------------------------------------------------------- config port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_a_q <= 32'(ONE);
			coef_b_q <= 32'(ONE);
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_COEF_A: coef_a_q <= pwdata;
				REG_COEF_B: coef_b_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_COEF_A: prdata = coef_a_q;
			REG_COEF_B: prdata = coef_b_q;
			default:    prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- flow control
	// One enable moves every stage; hold all while a result waits stalled.
	assign en        = !(res_valid && res_stall);
	assign cmd_stall = !en;

	// ---------------------------------------------------------------- q = (torque<<F)/speed
	// Stage 0 captures the word. Only 32 quotient bits matter: a larger quotient
	// exceeds any coef_b, so flag it (big) and drive d to zero.
	logic        a_vld_s [0:32];
	logic        a_spz_s [0:32];
	logic        a_big_s [0:32];
	logic [31:0] a_tq_s  [0:32];
	logic [31:0] a_sp_s  [0:32];
	logic [32:0] a_rem_s [0:32];
	logic [31:0] a_lo_s  [0:32];
	logic [31:0] a_q_s   [0:32];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_vld_s[0] <= 1'b0;
		end else if (en) begin
			a_vld_s[0] <= cmd_valid;
			a_spz_s[0] <= shaft_speed == 32'd0;
			a_big_s[0] <= 32'(torque_demand >> (32 - FRAC_BITS)) >= shaft_speed;
			a_tq_s[0]  <= torque_demand;
			a_sp_s[0]  <= shaft_speed;
			a_rem_s[0] <= 33'(torque_demand >> (32 - FRAC_BITS));
			a_lo_s[0]  <= 32'(torque_demand << FRAC_BITS);
			a_q_s[0]   <= '0;
		end
	end

	for (genvar j = 0; j < 32; j++) begin : g_div1
		logic [32:0] rt;
		logic        ge;
		assign rt = {a_rem_s[j][31:0], a_lo_s[j][31]};
		assign ge = rt >= {1'b0, a_sp_s[j]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				a_vld_s[j+1] <= 1'b0;
			end else if (en) begin
				a_vld_s[j+1] <= a_vld_s[j];
				a_spz_s[j+1] <= a_spz_s[j];
				a_big_s[j+1] <= a_big_s[j];
				a_tq_s[j+1]  <= a_tq_s[j];
				a_sp_s[j+1]  <= a_sp_s[j];
				a_rem_s[j+1] <= ge ? rt - {1'b0, a_sp_s[j]} : rt;
				a_lo_s[j+1]  <= a_lo_s[j] << 1;
				a_q_s[j+1]   <= {a_q_s[j][30:0], ge};
			end
		end
	end

	// ---------------------------------------------------------------- d and sqrt(d<<F)
	// Stage 0 forms d = max(B - q, 0); then one root bit per stage.
	logic          sq_vld_s [0:RN];
	logic          sq_spz_s [0:RN];
	logic          sq_dz_s  [0:RN];
	logic [31:0]   sq_tq_s  [0:RN];
	logic [SW-1:0] sq_val_s [0:RN];
	logic [RW-1:0] sq_rem_s [0:RN];
	logic [RN-1:0] sq_rt_s  [0:RN];

	logic [31:0] dv;
	always_comb begin
		if (!a_big_s[32] && (coef_b_q > a_q_s[32]))
			dv = coef_b_q - a_q_s[32];
		else
			dv = '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_vld_s[0] <= 1'b0;
		end else if (en) begin
			sq_vld_s[0] <= a_vld_s[32];
			sq_spz_s[0] <= a_spz_s[32];
			sq_dz_s[0]  <= dv == 32'd0;
			sq_tq_s[0]  <= a_tq_s[32];
			sq_val_s[0] <= SW'(64'(dv) << FRAC_BITS);
			sq_rem_s[0] <= '0;
			sq_rt_s[0]  <= '0;
		end
	end

	for (genvar j = 0; j < RN; j++) begin : g_sqrt
		logic [RW-1:0] r2, trial;
		logic          ge;
		assign r2    = {sq_rem_s[j][RW-3:0], sq_val_s[j][SW-1 -: 2]};
		assign trial = {sq_rt_s[j], 2'b01};
		assign ge    = r2 >= trial;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				sq_vld_s[j+1] <= 1'b0;
			end else if (en) begin
				sq_vld_s[j+1] <= sq_vld_s[j];
				sq_spz_s[j+1] <= sq_spz_s[j];
				sq_dz_s[j+1]  <= sq_dz_s[j];
				sq_tq_s[j+1]  <= sq_tq_s[j];
				sq_val_s[j+1] <= sq_val_s[j] << 2;
				sq_rem_s[j+1] <= ge ? r2 - trial : r2;
				sq_rt_s[j+1]  <= {sq_rt_s[j][RN-2:0], ge};
			end
		end
	end

	// ---------------------------------------------------------------- p = A * torque
	logic          pm_vld_s1, pm_spz_s1, pm_dz_s1, pm_tz_s1;
	logic [63:0]   pm_p_s1;
	logic [RN-1:0] pm_rt_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pm_vld_s1 <= 1'b0;
		end else if (en) begin
			pm_vld_s1 <= sq_vld_s[RN];
			pm_spz_s1 <= sq_spz_s[RN];
			pm_dz_s1  <= sq_dz_s[RN];
			pm_tz_s1  <= sq_tq_s[RN] == 32'd0;
			pm_p_s1   <= 64'(coef_a_q) * 64'(sq_tq_s[RN]);
			pm_rt_s1  <= sq_rt_s[RN];
		end
	end

	// ---------------------------------------------------------------- t = p / s
	// Only t below 1.0 matters: flag t >= 1.0 (big), then F quotient bits.
	logic           dq_vld_s [0:FRAC_BITS];
	logic           dq_spz_s [0:FRAC_BITS];
	logic           dq_dz_s  [0:FRAC_BITS];
	logic           dq_tz_s  [0:FRAC_BITS];
	logic           dq_big_s [0:FRAC_BITS];
	logic [RN-1:0]  dq_rt_s  [0:FRAC_BITS];
	logic [RN:0]    dq_rem_s [0:FRAC_BITS];
	logic [FRAC_BITS-1:0] dq_lo_s [0:FRAC_BITS];
	logic [FRAC_BITS-1:0] dq_q_s  [0:FRAC_BITS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dq_vld_s[0] <= 1'b0;
		end else if (en) begin
			dq_vld_s[0] <= pm_vld_s1;
			dq_spz_s[0] <= pm_spz_s1;
			dq_dz_s[0]  <= pm_dz_s1;
			dq_tz_s[0]  <= pm_tz_s1;
			dq_big_s[0] <= pm_p_s1 >= (64'(pm_rt_s1) << FRAC_BITS);
			dq_rt_s[0]  <= pm_rt_s1;
			dq_rem_s[0] <= (RN+1)'(pm_p_s1 >> FRAC_BITS);
			dq_lo_s[0]  <= pm_p_s1[FRAC_BITS-1:0];
			dq_q_s[0]   <= '0;
		end
	end

	for (genvar j = 0; j < FRAC_BITS; j++) begin : g_div2
		logic [RN:0] rt;
		logic        ge;
		assign rt = {dq_rem_s[j][RN-1:0], dq_lo_s[j][FRAC_BITS-1]};
		assign ge = rt >= {1'b0, dq_rt_s[j]};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dq_vld_s[j+1] <= 1'b0;
			end else if (en) begin
				dq_vld_s[j+1] <= dq_vld_s[j];
				dq_spz_s[j+1] <= dq_spz_s[j];
				dq_dz_s[j+1]  <= dq_dz_s[j];
				dq_tz_s[j+1]  <= dq_tz_s[j];
				dq_big_s[j+1] <= dq_big_s[j];
				dq_rt_s[j+1]  <= dq_rt_s[j];
				dq_rem_s[j+1] <= ge ? rt - {1'b0, dq_rt_s[j]} : rt;
				dq_lo_s[j+1]  <= dq_lo_s[j] << 1;
				dq_q_s[j+1]   <= {dq_q_s[j][FRAC_BITS-2:0], ge};
			end
		end
	end

	// ---------------------------------------------------------------- c and search target
	// c = 1 - t clamped at 0; d zero means an infinite term unless torque is zero.
	etft_ctl_t   sr_ctl [0:SRCH_BITS];
	logic [16:0] sr_y   [0:SRCH_BITS];
	logic [30:0] sr_tgt [0:SRCH_BITS];

	logic [FRAC_BITS:0] cval;
	always_comb begin
		if (dq_dz_s[FRAC_BITS])
			cval = dq_tz_s[FRAC_BITS] ? ONE : '0;
		else if (dq_big_s[FRAC_BITS])
			cval = '0;
		else
			cval = ONE - {1'b0, dq_q_s[FRAC_BITS]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sr_ctl[0] <= '0;
		end else if (en) begin
			sr_ctl[0].vld    <= dq_vld_s[FRAC_BITS];
			sr_ctl[0].force0 <= dq_spz_s[FRAC_BITS];
			sr_ctl[0].full   <= !dq_spz_s[FRAC_BITS] && (cval == '0);
			sr_y[0]          <= '0;
			sr_tgt[0]        <= 31'(32'(cval) << TSH);
		end
	end

	// ---------------------------------------------------------------- throttle bit search
	// Bit 16 down to bit 0; each step keeps its bit when the candidate is at most 1.0 and cos(candidate) >= target.
	for (genvar i = 0; i < SRCH_BITS; i++) begin : g_srch
		etft_srch #(
			.BIT(SRCH_BITS - 1 - i)
		) u_srch (
			.clk   (clk),
			.arst_n(arst_n),
			.en    (en),
			.ctl_i (sr_ctl[i]),
			.y_i   (sr_y[i]),
			.tgt_i (sr_tgt[i]),
			.ctl_o (sr_ctl[i+1]),
			.y_o   (sr_y[i+1]),
			.tgt_o (sr_tgt[i+1])
		);
	end

	// ---------------------------------------------------------------- output register
	logic             res_valid_q;
	logic [OUT_W-1:0] throttle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (en) begin
			res_valid_q <= sr_ctl[SRCH_BITS].vld;
			if (sr_ctl[SRCH_BITS].force0)
				throttle_q <= '0;
			else if (sr_ctl[SRCH_BITS].full)
				throttle_q <= OUT_ONE;
			else
				throttle_q <= sr_y[SRCH_BITS];
		end
	end

	assign res_valid = res_valid_q;
	assign throttle  = throttle_q;

endmodule
`default_nettype wire

// ===== rtl/core/etft_chk.sv =====
// Port-level checker for engine_throttle_from_torque, with its bind statement.
// Depends on etft_pkg for the output width and full-scale value.
`default_nettype none
module etft_chk import etft_pkg::*; (
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             cmd_stall,
	input wire logic             res_valid,
	input wire logic             res_stall,
	input wire logic [OUT_W-1:0] throttle
);

	// result never exceeds full throttle
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> throttle <= OUT_ONE)
		else $error("throttle above full scale");

	// command side stalls only while a result is held stalled
	a_stall_src: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_stall |-> (res_valid && res_stall))
		else $error("command stalled without a held result");

	// stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && res_stall) |=> (res_valid && $stable(throttle)))
		else $error("stalled result changed");

endmodule

bind engine_throttle_from_torque etft_chk u_etft_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.cmd_stall(cmd_stall),
	.res_valid(res_valid),
	.res_stall(res_stall),
	.throttle (throttle)
);
`default_nettype wire

// ===== tb/sv/tb_engine_throttle_from_torque.sv =====
// Testbench for engine_throttle_from_torque: drives torque/speed words, predicts the throttle.
// Depends on etft_pkg and the engine_throttle_from_torque RTL.
`timescale 1ns / 100ps
`default_nettype none
module tb_engine_throttle_from_torque;
	import etft_pkg::*;

	localparam int FB = 16;
	localparam int LAT = 600;
	// register byte addresses
	localparam logic [2:0] ADDR_COEF_A = {REG_COEF_A, 2'b00};
	localparam logic [2:0] ADDR_COEF_B = {REG_COEF_B, 2'b00};

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	logic [31:0] torque_demand = '0, shaft_speed = '0;
	logic res_valid;
	logic res_stall = 1'b0;
	logic [OUT_W-1:0] throttle;

	// local copy of the engine constants
	logic [31:0] mdl_coef_a, mdl_coef_b;
	logic [16:0] throttle_q[$];
	int errors = 0;
	bit calm = 1'b0;   // suppress idling on both sides

	engine_throttle_from_torque uut (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic logic [63:0] root64(logic [63:0] v);
		logic [63:0] res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv >>= 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v -= res + bitv;
				res = (res >> 1) + bitv;
			end else begin
				res >>= 1;
			end
			bitv >>= 2;
		end
		return res;
	endfunction

	// cos(pi/2 * y / 2^16) as a Q2.30 Taylor sum
	function automatic longint cosine_q30(logic [63:0] y);
		logic [63:0] x, x2, term;
		longint sum;
		x = (64'd1686629713 * y) >> 16;
		x2 = (x * x) >> 30;
		term = 64'd1 << 30;
		sum = longint'(term);
		for (int k = 1; k <= 8; k++) begin
			term = ((term * x2) >> 30) / ((2 * k - 1) * (2 * k));
			if (k % 2) sum -= longint'(term);
			else sum += longint'(term);
		end
		return sum;
	endfunction

	function automatic logic [16:0] throttle_for(logic [31:0] torque, logic [31:0] speed);
		logic [63:0] q, d, s, t, c, y, cand;
		longint target;
		if (speed == 0) return '0;
		q = ({32'd0, torque} << FB) / speed;
		d = (mdl_coef_b > q) ? mdl_coef_b - q : 0;
		if (d == 0) begin
			c = (torque == 0) ? (64'd1 << FB) : 0;
		end else begin
			s = root64(d << FB);
			t = (64'(mdl_coef_a) * torque) / s;
			c = (t < (64'd1 << FB)) ? (64'd1 << FB) - t : 0;
		end
		if (c == 0) return OUT_ONE;
		target = longint'(c << (30 - FB));
		y = 0;
		for (int b = 16; b >= 0; b--) begin
			cand = y | (64'd1 << b);
			if (cand <= 65536 && cosine_q30(cand) >= target) y = cand;
		end
		return y[16:0];
	endfunction

	// result side: random stall, check every accepted word
	always @(posedge clk) begin
		if (arst_n) begin
			if (res_valid && !res_stall) begin
				if (throttle_q.size() == 0) begin
					$display("%0t: unexpected throttle %0d", $time, throttle);
					errors++;
				end else begin
					logic [16:0] want;
					want = throttle_q.pop_front();
					if (throttle !== want) begin
						$display("%0t: throttle expected %0d actual %0d", $time, want, throttle);
						errors++;
					end
				end
			end
			res_stall <= calm ? 1'b0 : ($urandom_range(99) < 30);
		end
	end

	// one APB write, only while the pipeline is empty
	task automatic write_reg(logic [2:0] addr, logic [31:0] val);
		psel <= 1'b1; pwrite <= 1'b1; paddr <= addr; pwdata <= val; penable <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (addr == ADDR_COEF_A) mdl_coef_a = val;
		else mdl_coef_b = val;
	endtask

	// send one word, with random idle beforehand unless calm; valid stays high into the next word
	task automatic send_word(logic [31:0] torque, logic [31:0] speed);
		if (!calm) begin
			while ($urandom_range(99) < 30) begin
				cmd_valid <= 1'b0;
				@(posedge clk);
			end
		end
		cmd_valid <= 1'b1;
		torque_demand <= torque;
		shaft_speed <= speed;
		do @(posedge clk); while (cmd_stall);
		throttle_q.push_back(throttle_for(torque, speed));
	endtask

	task automatic drain();
		cmd_valid <= 1'b0;
		while (throttle_q.size() != 0) @(posedge clk);
		repeat (LAT) @(posedge clk);
	endtask

	task automatic set_coefs(logic [31:0] a, logic [31:0] b);
		drain();
		write_reg(ADDR_COEF_A, a);
		write_reg(ADDR_COEF_B, b);
	endtask

	// draw a value that is often small, sometimes near the top, sometimes anything
	function automatic logic [31:0] pick_val();
		case ($urandom_range(3))
			0: return $urandom_range(32'h0002_0000);
			1: return $urandom_range(32'h0040_0000);
			2: return 32'hFFFF_FFFF - $urandom_range(255);
			default: return $urandom;
		endcase
	endfunction

	task automatic test_directed();
		send_word(32'h0001_0000, 32'd0);          // zero speed
		send_word(32'hFFFF_FFFF, 32'd0);
		send_word(32'd0, 32'h0001_0000);          // zero torque
		send_word(32'hFFFF_FFFF, 32'd1);          // d zero with torque: full
		send_word(32'd0, 32'hFFFF_FFFF);
		send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(32'h0000_4000, 32'h0001_0000);
		send_word(32'h0000_1000, 32'h0004_0000);
		send_word(32'd1, 32'hFFFF_FFFF);
		send_word(32'h0000_8000, 32'h0002_0000);
		set_coefs(32'd1, 32'hFFFF_FFFF);          // extreme constants
		send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(32'h0001_0000, 32'h0001_0000);
		send_word(32'd1, 32'd1);
		set_coefs(32'hFFFF_FFFF, 32'd1);
		send_word(32'd0, 32'd1);                  // zero torque, d = 1
		send_word(32'd1, 32'hFFFF_FFFF);
		send_word(32'h0000_0100, 32'h0010_0000);
		set_coefs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(32'd1, 32'hFFFF_FFFF);
		send_word(32'h0000_0010, 32'h0000_0010);
	endtask

	task automatic test_random(int count);
		for (int i = 0; i < count; i++) begin
			calm = (i >= count / 2 && i < count / 2 + 120);
			send_word(pick_val(), ($urandom_range(19) == 0) ? 32'd0 : pick_val());
		end
		calm = 1'b0;
	endtask

	task automatic test_sweeps();
		set_coefs(32'h0000_0100, 32'h0010_0000);
		test_random(280);
		set_coefs(32'h0001_0000, 32'h0001_0000);
		test_random(280);
		set_coefs($urandom, $urandom_range(32'h1000_0000, 1));
		test_random(280);
		set_coefs($urandom_range(32'h0000_4000, 1), $urandom);
		test_random(280);
	endtask

	initial begin
		mdl_coef_a = 32'h0001_0000;
		mdl_coef_b = 32'h0001_0000;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_sweeps();
		drain();
		if (errors == 0) $display("SCOREBOARD CLEAN");
		else $display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		#20ms;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
`default_nettype wire
